@@ rtl/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    localparam int HEAP_WORDS    = 32768;
    localparam int TABLE_DEPTH   = 2048;
    localparam int WORD_BYTES    = 8;
    localparam int HEADER_WORDS  = 4;

    localparam int ADDR_W  = 15;
    localparam int LEN_W   = 16;
    localparam int BYTES_W = 18;
    localparam int NEED_W  = 17;
    localparam int WB_SHIFT = $clog2(WORD_BYTES);

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOFIT   = 2'd1;
    localparam t_status ST_UNALLOC = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        logic   v;
        t_entry ent;
    } t_cell;

    typedef struct packed {
        logic  shift;
        t_cell tail;
    } t_ring_ctl;

    localparam t_entry INIT_RUN  = '{start: '0, len: LEN_W'(HEAP_WORDS)};
    localparam t_cell  INIT_CELL = '{v: 1'b1, ent: INIT_RUN};

endpackage
`default_nettype wire

@@ rtl/ffha_cell.sv @@
// One table cell: holds one entry and takes its neighbor's entry on a shift.
`default_nettype none
module ffha_cell #(
    parameter bit INIT_EN = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  ffha_pkg::t_cell i_next,
    output ffha_pkg::t_cell o_entry
);
    import ffha_pkg::*;

    t_cell r_entry;

    generate
        if (INIT_EN) begin : g_init
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_entry <= INIT_CELL;
                end else if (i_shift) begin
                    r_entry <= i_next;
                end
            end
        end else begin : g_plain
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_entry.v <= 1'b0;
                end else if (i_shift) begin
                    r_entry <= i_next;
                end
            end
        end
    endgenerate

    assign o_entry = r_entry;

endmodule
`default_nettype wire

@@ rtl/ffha_chain.sv @@
// Ring of table cells; the head cell is read, the tail cell takes the written entry.
`default_nettype none
module ffha_chain #(
    parameter int DEPTH     = ffha_pkg::TABLE_DEPTH,
    parameter bit INIT_HEAD = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffha_pkg::t_ring_ctl i_ctl,
    output ffha_pkg::t_cell     o_head
);
    import ffha_pkg::*;

    t_cell w_cell [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            if (k == DEPTH - 1) begin : g_tail
                ffha_cell #(.INIT_EN(INIT_HEAD && (k == 0))) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_shift(i_ctl.shift),
                    .i_next (i_ctl.tail),
                    .o_entry(w_cell[k])
                );
            end else begin : g_mid
                ffha_cell #(.INIT_EN(INIT_HEAD && (k == 0))) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_shift(i_ctl.shift),
                    .i_next (w_cell[k+1]),
                    .o_entry(w_cell[k])
                );
            end
        end
    endgenerate

    assign o_head = w_cell[0];

endmodule
`default_nettype wire

@@ rtl/ffha_ctrl.sv @@
// Sequencer: streams the tables through the ring heads, coalesces, searches, inserts, removes.
`default_nettype none
module ffha_ctrl #(
    parameter int DEPTH = ffha_pkg::TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_operation,
    input  logic [ffha_pkg::BYTES_W-1:0]  i_request_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]   i_block_address,
    input  ffha_pkg::t_cell               i_free_head,
    input  ffha_pkg::t_cell               i_used_head,
    output ffha_pkg::t_ring_ctl           o_free_ctl,
    output ffha_pkg::t_ring_ctl           o_used_ctl,
    output logic                          o_valid,
    output logic [ffha_pkg::ADDR_W-1:0]   o_granted_address,
    output ffha_pkg::t_status             o_status
);
    import ffha_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_FREE_SCAN = 6'b000010,
        S_USED_INS  = 6'b000100,
        S_USED_SCAN = 6'b001000,
        S_FREE_INS  = 6'b010000,
        S_RESP      = 6'b100000
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_t;
    logic [CNT_W-1:0]   r_free_cnt;
    logic [CNT_W-1:0]   r_used_cnt;
    logic [CNT_W-1:0]   r_wcnt;
    logic               r_done;
    logic               r_acc_v;
    t_entry             r_acc;
    t_entry             r_key;
    logic [NEED_W-1:0]  r_need;
    logic [1:0]         r_q_v;
    t_entry             r_q [2];
    logic [ADDR_W-1:0]  r_gs;
    logic [ADDR_W-1:0]  r_granted;
    t_status            r_status;

    logic               n_done;
    logic               n_acc_v;
    t_entry             n_acc;
    t_entry             n_key;
    logic [ADDR_W-1:0]  n_gs;
    logic [1:0]         n_q_v;
    t_entry             n_q [2];

    logic               pass;
    logic               last;
    logic               x_v;
    t_entry             x;
    logic               used_full;
    logic               free_full;
    logic               merge;
    logic               flush;
    logic               fit;
    logic [LEN_W-1:0]   tail_len;
    logic [1:0]         c_v;
    t_entry             c [2];
    logic [3:0]         e_v;
    t_entry             e [4];
    logic [3:0]         l_v;
    t_entry             l [4];
    logic               pop;
    logic [CNT_W-1:0]   wcnt_next;
    logic [BYTES_W:0]   bytes_up;
    logic [NEED_W-1:0]  need;

    assign pass = (r_state == S_FREE_SCAN) || (r_state == S_USED_INS) ||
                  (r_state == S_USED_SCAN) || (r_state == S_FREE_INS);
    assign last = (r_t == CNT_W'(DEPTH));
    assign x_v  = !last && (((r_state == S_FREE_SCAN) || (r_state == S_FREE_INS)) ?
                  i_free_head.v : i_used_head.v);
    assign x    = ((r_state == S_FREE_SCAN) || (r_state == S_FREE_INS)) ?
                  i_free_head.ent : i_used_head.ent;
    assign used_full = (r_used_cnt == CNT_W'(DEPTH));
    assign free_full = (r_free_cnt == CNT_W'(DEPTH));

    assign bytes_up = {1'b0, i_request_bytes} + (BYTES_W+1)'(WORD_BYTES - 1);
    assign need     = NEED_W'(bytes_up >> WB_SHIFT) + NEED_W'(HEADER_WORDS);

    assign merge = x_v && r_acc_v &&
                   (({2'b00, r_acc.start} + {1'b0, r_acc.len}) == {2'b00, x.start});
    assign flush = r_acc_v && ((x_v && !merge) || last);
    assign fit   = !r_done && ({1'b0, r_acc.len} >= r_need);
    assign tail_len = r_acc.len - r_need[LEN_W-1:0];

    always_comb begin
        c_v     = 2'b00;
        c[0]    = x;
        c[1]    = x;
        n_done  = r_done;
        n_acc_v = r_acc_v;
        n_acc   = r_acc;
        n_key   = r_key;
        n_gs    = r_gs;
        case (r_state)
            S_FREE_SCAN: begin
                if (flush) begin
                    if (fit && !used_full) begin
                        c_v[0]       = (tail_len != '0);
                        c[0].start   = r_acc.start + r_need[ADDR_W-1:0];
                        c[0].len     = tail_len;
                    end else begin
                        c_v[0] = 1'b1;
                        c[0]   = r_acc;
                    end
                    if (fit) begin
                        n_done = 1'b1;
                        n_gs   = r_acc.start;
                    end
                end
                if (merge) begin
                    n_acc.len = r_acc.len + x.len;
                end else if (x_v) begin
                    n_acc_v = 1'b1;
                    n_acc   = x;
                end
            end
            S_USED_INS, S_FREE_INS: begin
                if (!r_done && ((x_v && (x.start > r_key.start)) || last)) begin
                    c_v[0] = 1'b1;
                    c[0]   = r_key;
                    c_v[1] = x_v;
                    n_done = 1'b1;
                end else begin
                    c_v[0] = x_v;
                end
            end
            S_USED_SCAN: begin
                if (x_v && !r_done && (x.start == r_key.start)) begin
                    n_done = 1'b1;
                    n_key  = x;
                    c_v[0] = free_full;
                end else begin
                    c_v[0] = x_v;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        logic [2:0] k;
        k    = '0;
        e_v  = {c_v[1], c_v[0], r_q_v[1], r_q_v[0]};
        e[0] = r_q[0];
        e[1] = r_q[1];
        e[2] = c[0];
        e[3] = c[1];
        l_v  = '0;
        for (int i = 0; i < 4; i++) begin
            l[i] = e[i];
        end
        for (int i = 0; i < 4; i++) begin
            if (e_v[i]) begin
                l[k[1:0]]   = e[i];
                l_v[k[1:0]] = 1'b1;
                k           = k + 3'd1;
            end
        end
    end

    assign pop       = (r_t != '0) && l_v[0];
    assign wcnt_next = r_wcnt + CNT_W'(pop);

    always_comb begin
        if (pop) begin
            n_q_v = l_v[2:1];
            n_q[0] = l[1];
            n_q[1] = l[2];
        end else begin
            n_q_v = l_v[1:0];
            n_q[0] = l[0];
            n_q[1] = l[1];
        end
    end

    assign o_free_ctl.shift = (r_state == S_FREE_SCAN) || (r_state == S_FREE_INS);
    assign o_free_ctl.tail  = '{v: pop, ent: l[0]};
    assign o_used_ctl.shift = (r_state == S_USED_INS) || (r_state == S_USED_SCAN);
    assign o_used_ctl.tail  = '{v: pop, ent: l[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_free_cnt <= CNT_W'(1);
            r_used_cnt <= '0;
            r_q_v      <= '0;
            r_done     <= 1'b0;
            r_acc_v    <= 1'b0;
            r_t        <= '0;
            r_wcnt     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_t     <= '0;
                        r_wcnt  <= '0;
                        r_done  <= 1'b0;
                        r_acc_v <= 1'b0;
                        r_q_v   <= '0;
                        if (i_operation == OP_ALLOC) begin
                            r_need <= need;
                            if ((need == '0) || (need >= NEED_W'(HEAP_WORDS))) begin
                                r_status  <= ST_NOFIT;
                                r_granted <= '0;
                                r_state   <= S_RESP;
                            end else begin
                                r_state  <= S_FREE_SCAN;
                            end
                        end else begin
                            r_key.start <= i_block_address;
                            r_state     <= S_USED_SCAN;
                        end
                    end
                end
                S_FREE_SCAN, S_USED_INS, S_USED_SCAN, S_FREE_INS: begin
                    r_t     <= r_t + CNT_W'(1);
                    r_wcnt  <= wcnt_next;
                    r_done  <= n_done;
                    r_acc_v <= n_acc_v;
                    r_acc   <= n_acc;
                    r_key   <= n_key;
                    r_gs    <= n_gs;
                    r_q_v   <= n_q_v;
                    r_q     <= n_q;
                    if (last) begin
                        r_t     <= '0;
                        r_wcnt  <= '0;
                        r_done  <= 1'b0;
                        r_acc_v <= 1'b0;
                        r_q_v   <= '0;
                        r_state <= S_RESP;
                        unique case (r_state)
                            S_FREE_SCAN: begin
                                r_free_cnt <= wcnt_next;
                                r_granted  <= '0;
                                if (!n_done) begin
                                    r_status <= ST_NOFIT;
                                end else if (used_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status  <= ST_OK;
                                    r_granted <= n_gs;
                                    r_key     <= '{start: n_gs, len: r_need[LEN_W-1:0]};
                                    r_state   <= S_USED_INS;
                                end
                            end
                            S_USED_SCAN: begin
                                r_used_cnt <= wcnt_next;
                                r_granted  <= '0;
                                if (!n_done) begin
                                    r_status <= ST_UNALLOC;
                                end else if (free_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_key    <= n_key;
                                    r_state  <= S_FREE_INS;
                                end
                            end
                            S_USED_INS: begin
                                r_used_cnt <= wcnt_next;
                            end
                            default: begin
                                r_free_cnt <= wcnt_next;
                            end
                        endcase
                    end
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_RESP);
    assign o_granted_address = r_granted;
    assign o_status          = r_status;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("transaction not taken");
    a_queue_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pass && last) |-> !n_q_v[0]) else $error("entries left at end of pass");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_cnt <= CNT_W'(DEPTH)) && (r_used_cnt <= CNT_W'(DEPTH)))
        else $error("table count out of range");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_granted_address == '0))
        else $error("address on failed request");

endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator_unit.sv @@
// Top level of the first-fit heap allocator: free and used rings plus sequencer.
// Sequencing: allocate and release make two full table passes when they change the
// tables, one when they fail after the first table pass, and none for an oversize request.
// Throughput: one transaction at a time; each table pass rotates the whole cell ring.
// Result: one cycle on o_valid; the receiver cannot stall.
// Reset: synchronous; free table holds one run covering the heap, used table empty.
`default_nettype none
module first_fit_heap_allocator_unit #(
    parameter int TABLE_DEPTH = ffha_pkg::TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [ffha_pkg::BYTES_W-1:0]  i_request_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]   i_block_address,
    output logic                          o_valid,
    output logic [ffha_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [1:0]                    o_status
);
    import ffha_pkg::*;

    t_cell     w_free_head;
    t_cell     w_used_head;
    t_ring_ctl w_free_ctl;
    t_ring_ctl w_used_ctl;

    ffha_chain #(.DEPTH(TABLE_DEPTH), .INIT_HEAD(1'b1)) u_free (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_free_ctl),
        .o_head (w_free_head)
    );

    ffha_chain #(.DEPTH(TABLE_DEPTH), .INIT_HEAD(1'b0)) u_used (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_used_ctl),
        .o_head (w_used_head)
    );

    ffha_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_block_address  (i_block_address),
        .i_free_head      (w_free_head),
        .i_used_head      (w_used_head),
        .o_free_ctl       (w_free_ctl),
        .o_used_ctl       (w_used_ctl),
        .o_valid          (o_valid),
        .o_granted_address(o_granted_address),
        .o_status         (o_status)
    );

endmodule
`default_nettype wire
